/* src/spc_pkg.sv */
// ============================================================================
// spc_pkg: shared types and constants for the secured prefix cache
// Holds status codes, the entry record, the item structs and default sizes.
// ============================================================================
package spc_pkg;

    localparam int unsigned CACHE_ENTRIES_DEFAULT = 16;

    localparam logic [31:0] LIFE_INFINITE = 32'hffff_ffff;
    localparam logic [7:0]  AUTOCONF_LEN  = 8'd64;
    localparam logic [7:0]  MAX_LEN       = 8'h80;
    localparam int unsigned FLAG_AUTO_BIT = 6;

    localparam logic [3:0] ST_IGNORED   = 4'd0;
    localparam logic [3:0] ST_CONFLICT  = 4'd1;
    localparam logic [3:0] ST_UNSEC_OK  = 4'd2;
    localparam logic [3:0] ST_DELETED   = 4'd3;
    localparam logic [3:0] ST_ABSENT    = 4'd4;
    localparam logic [3:0] ST_REFRESHED = 4'd5;
    localparam logic [3:0] ST_INSERTED  = 4'd6;
    localparam logic [3:0] ST_FULL      = 4'd7;
    localparam logic [3:0] ST_SWEPT     = 4'd8;

    localparam logic OP_OPTION = 1'b0;
    localparam logic OP_SWEEP  = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [31:0] now_seconds;
        logic [15:0] interface_req;
        logic        secure;
        logic [63:0] prefix_high;
        logic [63:0] prefix_low;
        logic [7:0]  prefix_len;
        logic [7:0]  option_flags;
        logic [31:0] valid_life;
        logic [31:0] preferred_life;
    } req_t;

    typedef struct packed {
        logic [3:0] status;
        logic       autoconf_request;
        logic [4:0] removed_count;
        logic [4:0] entries_left;
    } rsp_t;

    typedef struct packed {
        logic [15:0] ifc;
        logic [63:0] prefix_high;
        logic [63:0] prefix_low;
        logic [7:0]  length;
        logic [7:0]  flags;
        logic [31:0] valid_secs;
        logic [31:0] pref_secs;
        logic [32:0] expiry;
    } entry_t;

    // Mask of the leading len bits of a 128-bit prefix.
    function automatic logic [127:0] prefix_mask(input logic [7:0] len);
        logic [127:0] m;
        m = '1;
        if (len >= MAX_LEN)
            prefix_mask = m;
        else
            prefix_mask = ~(m >> len[6:0]);
    endfunction

endpackage

/* src/spc_if.sv */
// ============================================================================
// spc_if: valid/ready channel
// Carries one item of a generic payload type between a source and a sink.
// ============================================================================
interface spc_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* src/spc_match.sv */
// ============================================================================
// spc_match: entry compare unit
// Shared compare used by the sequencer, one entry at a time: prefix match
// against a request and the expiry test of a sweep.
// ============================================================================
module spc_match (
    input  spc_pkg::entry_t entry,
    input  logic [15:0]     ifc,
    input  logic [63:0]     prefix_high,
    input  logic [63:0]     prefix_low,
    input  logic [31:0]     now_seconds,
    output logic            hit,
    output logic            expired
);
    logic [127:0] mask;

    always_comb
    begin
        mask = spc_pkg::prefix_mask(entry.length);
        hit = (entry.ifc == ifc)
            && ((({prefix_high, prefix_low} ^ {entry.prefix_high, entry.prefix_low})
                 & mask) == 128'd0);
        expired = entry.expiry < {1'b0, now_seconds};
    end
endmodule

/* src/spc_core.sv */
// ============================================================================
// spc_core: cache store and sequencer
// Walks the entry memory one slot at a time to search, sweep, compact and write.
// ============================================================================
module spc_core #(
    parameter int unsigned CACHE_ENTRIES = spc_pkg::CACHE_ENTRIES_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         autoconf_enable,
    spc_if.sink          req,
    spc_if.source        rsp
);
    localparam int unsigned IW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int unsigned CW = $clog2(CACHE_ENTRIES + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_TEST, S_SHIFT_RD, S_SHIFT_WR, S_WRITE, S_DONE
    } state_t;

    spc_pkg::entry_t mem [CACHE_ENTRIES];

    state_t          state_reg;
    spc_pkg::req_t   req_reg;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   idx_reg;
    logic [CW-1:0]   dst_reg;
    logic [4:0]      removed_reg;
    logic [3:0]      status_reg;
    logic            auto_reg;
    logic            found_reg;
    logic [CW-1:0]   hit_reg;
    spc_pkg::entry_t rd_reg;
    logic            out_valid_reg;
    spc_pkg::rsp_t   out_reg;

    logic            hit;
    logic            expired;
    spc_pkg::entry_t wr_entry;
    logic [7:0]      plen_sat;

    spc_match u_match (
        .entry       (rd_reg),
        .ifc         (req_reg.interface_req),
        .prefix_high (req_reg.prefix_high),
        .prefix_low  (req_reg.prefix_low),
        .now_seconds (req_reg.now_seconds),
        .hit         (hit),
        .expired     (expired)
    );

    assign plen_sat = (req_reg.prefix_len > spc_pkg::MAX_LEN)
        ? spc_pkg::MAX_LEN : req_reg.prefix_len;

    always_comb
    begin
        wr_entry = rd_reg;
        if (!found_reg)
        begin
            wr_entry.ifc         = req_reg.interface_req;
            wr_entry.prefix_high = req_reg.prefix_high;
            wr_entry.prefix_low  = req_reg.prefix_low;
            wr_entry.length      = plen_sat;
            wr_entry.flags       = req_reg.option_flags;
        end
        wr_entry.valid_secs = req_reg.valid_life;
        wr_entry.pref_secs  = req_reg.preferred_life;
        if (req_reg.valid_life == spc_pkg::LIFE_INFINITE)
            wr_entry.expiry = {1'b0, spc_pkg::LIFE_INFINITE};
        else
            wr_entry.expiry = {1'b0, req_reg.now_seconds} + {1'b0, req_reg.valid_life};
    end

    assign req.ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    // Entry memory: read registered, one write port.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_READ || state_reg == S_SHIFT_RD)
            rd_reg <= mem[idx_reg[IW-1:0]];
        if (state_reg == S_SHIFT_WR)
            mem[dst_reg[IW-1:0]] <= rd_reg;
        else if (state_reg == S_WRITE)
            mem[hit_reg[IW-1:0]] <= wr_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            dst_reg       <= '0;
            removed_reg   <= '0;
            found_reg     <= 1'b0;
            hit_reg       <= '0;
            status_reg    <= spc_pkg::ST_IGNORED;
            auto_reg      <= 1'b0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid && req.ready)
                    begin
                        req_reg     <= req.data;
                        idx_reg     <= '0;
                        dst_reg     <= '0;
                        removed_reg <= '0;
                        found_reg   <= 1'b0;
                        auto_reg    <= 1'b0;
                        if (req.data.opcode == spc_pkg::OP_OPTION
                            && req.data.preferred_life > req.data.valid_life)
                        begin
                            status_reg <= spc_pkg::ST_IGNORED;
                            state_reg  <= S_DONE;
                        end
                        else if (count_reg == '0)
                            state_reg <= S_TEST;
                        else
                            state_reg <= S_READ;
                    end
                end
                S_READ:
                    state_reg <= S_TEST;
                S_TEST:
                begin
                    // idx_reg == count_reg means the walk is over.
                    if (req_reg.opcode == spc_pkg::OP_SWEEP)
                    begin
                        if (idx_reg == count_reg)
                        begin
                            removed_reg <= 5'(count_reg - dst_reg);
                            count_reg   <= dst_reg;
                            status_reg  <= spc_pkg::ST_SWEPT;
                            state_reg   <= S_DONE;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + 1'b1;
                            if (!expired)
                            begin
                                state_reg <= S_SHIFT_WR;
                            end
                            else if (idx_reg + 1'b1 == count_reg)
                                state_reg <= S_TEST;
                            else
                                state_reg <= S_READ;
                        end
                    end
                    else if (idx_reg != count_reg && !found_reg && hit)
                    begin
                        found_reg <= 1'b1;
                        hit_reg   <= idx_reg;
                        dst_reg   <= idx_reg;
                        idx_reg   <= idx_reg + 1'b1;
                        if (!req_reg.secure)
                        begin
                            status_reg <= spc_pkg::ST_CONFLICT;
                            state_reg  <= S_DONE;
                        end
                        else if (req_reg.valid_life == '0)
                        begin
                            status_reg  <= spc_pkg::ST_DELETED;
                            removed_reg <= 5'd1;
                            if (idx_reg + 1'b1 == count_reg)
                            begin
                                count_reg <= count_reg - 1'b1;
                                state_reg <= S_DONE;
                            end
                            else
                                state_reg <= S_SHIFT_RD;
                        end
                        else
                        begin
                            status_reg <= spc_pkg::ST_REFRESHED;
                            auto_reg   <= 1'b1;
                            state_reg  <= S_WRITE;
                        end
                    end
                    else if (idx_reg + 1'b1 < count_reg)
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_READ;
                    end
                    else
                    begin
                        // No entry matched.
                        state_reg <= S_DONE;
                        if (!req_reg.secure)
                        begin
                            status_reg <= spc_pkg::ST_UNSEC_OK;
                            auto_reg   <= 1'b1;
                        end
                        else if (req_reg.valid_life == '0)
                            status_reg <= spc_pkg::ST_ABSENT;
                        else if (count_reg >= CW'(CACHE_ENTRIES))
                            status_reg <= spc_pkg::ST_FULL;
                        else
                        begin
                            status_reg <= spc_pkg::ST_INSERTED;
                            auto_reg   <= 1'b1;
                            hit_reg    <= count_reg;
                            count_reg  <= count_reg + 1'b1;
                            state_reg  <= S_WRITE;
                        end
                    end
                end
                S_SHIFT_RD:
                    state_reg <= S_SHIFT_WR;
                S_SHIFT_WR:
                begin
                    dst_reg <= dst_reg + 1'b1;
                    if (req_reg.opcode == spc_pkg::OP_SWEEP)
                    begin
                        state_reg <= (idx_reg == count_reg) ? S_TEST : S_READ;
                    end
                    else if (idx_reg + 1'b1 == count_reg)
                    begin
                        count_reg <= count_reg - 1'b1;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_SHIFT_RD;
                    end
                end
                S_WRITE:
                    state_reg <= S_DONE;
                S_DONE:
                begin
                    out_valid_reg <= 1'b1;
                    out_reg.status <= status_reg;
                    out_reg.autoconf_request <= auto_reg
                        && req_reg.option_flags[spc_pkg::FLAG_AUTO_BIT]
                        && autoconf_enable && (plen_sat == spc_pkg::AUTOCONF_LEN);
                    out_reg.removed_count <= removed_reg;
                    out_reg.entries_left  <= 5'(count_reg);
                    state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CACHE_ENTRIES))
        else $error("entry count above capacity");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !req.ready)
        else $error("ready while busy");
    a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |=> out_valid_reg)
        else $error("result not raised");
endmodule

/* src/secured_prefix_cache.sv */
// ============================================================================
// secured_prefix_cache: top level of the secured prefix cache
// One item at a time; holds the configuration register and the core.
// ============================================================================
// Work per item: an ignored option goes straight to the result; a search reads
// and tests each entry in turn, then writes the entry on a refresh or insert.
// A delete with compaction reads and writes back each later entry; a sweep tests
// each entry and writes back every kept one, so expired entries drop out.
// Throughput: one item at a time; the next is taken once the result has been
// accepted, so the walk over the entry memory sets the rate.
// Reset: the cache empties at once; autoconf_enable resets to 1.
module secured_prefix_cache #(
    parameter int unsigned CACHE_ENTRIES = spc_pkg::CACHE_ENTRIES_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    spc_if.sink  cfg,
    spc_if.sink  in_ch,
    spc_if.source out_ch
);
    logic autoconf_enable_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            autoconf_enable_reg <= 1'b1;
        else if (cfg.valid && cfg.ready)
            autoconf_enable_reg <= cfg.data;
    end

    spc_core #(.CACHE_ENTRIES(CACHE_ENTRIES)) u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .autoconf_enable (autoconf_enable_reg),
        .req             (in_ch),
        .rsp             (out_ch)
    );
endmodule
